/* hdl/cca_pkg.sv */
package cca_pkg;

   // default cluster count of the data heap
   localparam int unsigned CLUSTERS_DEF = 4096;

   // chain entry that ends a chain
   localparam logic [31:0] END_MARK = 32'hFFFF_FFFF;

   localparam int unsigned REQ_W = 56;
   localparam int unsigned RSP_W = 80;

   // csr register indexes
   localparam logic CSR_HEAP_FIRST = 1'b0;
   localparam logic CSR_SPC_LOG2   = 1'b1;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_FIND  = 2'd2,
      MODE_LINK  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_CLUSTER = 2'd1,
      ST_PAST_END    = 2'd2,
      ST_NO_FREE     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_CLR    = 4'd1,
      OP_LOAD   = 4'd2,
      OP_A_NEXT = 4'd3,
      OP_A_MARK = 4'd4,
      OP_A_LINK = 4'd5,
      OP_FREE   = 4'd6,
      OP_FIND   = 4'd7,
      OP_LINK   = 4'd8,
      OP_FIN    = 4'd9
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     clear_done;
      logic     contig;
      logic     cl_lt2;
      logic     cl_gt_last;
      logic     run_past;
      logic     map_bit;
      logic     nx_stop;
      logic     scan_fail;
      logic     idx_done;
      logic     last_idx;
      logic     cur_out;
      logic     rsp_busy;
   } flags_type;

endpackage

/* hdl/cca_dpath.sv */
module cca_dpath #(
   parameter int unsigned CLUSTERS = cca_pkg::CLUSTERS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [cca_pkg::REQ_W-1:0] req_tdata,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [31:0]               csr_wdata,
   input  cca_pkg::cmd_type          cmd,
   output cca_pkg::flags_type        flags,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [cca_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int unsigned AW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int unsigned CW = $clog2(CLUSTERS + 3);
   localparam int unsigned FW = $clog2(CLUSTERS + 1);
   localparam logic [CW-1:0] FIRST  = CW'(2);
   localparam logic [CW-1:0] LAST_C = CW'(CLUSTERS + 1);
   localparam logic [32:0]   LAST_W = 33'(CLUSTERS + 1);

   // map and chain table
   logic        map_mem_ff [CLUSTERS];
   logic [31:0] tab_mem_ff [CLUSTERS];
   logic        map_rd_ff;
   logic [31:0] tab_rd_ff;
   logic [AW-1:0] addr;
   logic        map_we, map_wd, tab_we;
   logic [31:0] tab_wd;

   // job registers
   cca_pkg::mode_type mode_ff, mode_in;
   logic [31:0]   cl_ff, cl_in;
   logic          contig_ff, contig_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [15:0]   idx_ff, idx_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [CW-1:0] start_ff, start_in;
   logic          wrap_ff, wrap_in;
   logic [CW-1:0] hint_ff, hint_in;
   logic [FW-1:0] free_ff, free_in;
   logic [31:0]   hfs_ff, hfs_in;
   logic [4:0]    spc_ff, spc_in;

   // result registers
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [12:0]   rsp_found_ff, rsp_found_in;
   logic [47:0]   rsp_sector_ff, rsp_sector_in;
   logic [12:0]   rsp_free_ff, rsp_free_in;

   // request fields
   cca_pkg::mode_type req_mode;
   logic [31:0] req_cl;
   logic        req_contig;
   logic [15:0] req_cnt;

   logic [CW-1:0] start_now, scan_nxt;
   logic          scan_nxt_wrap;
   logic [32:0]   run_end;
   logic [47:0]   sect_off;
   logic          ok_found;

   assign req_mode   = cca_pkg::mode_type'(req_tdata[1:0]);
   assign req_cl     = req_tdata[33:2];
   assign req_contig = req_tdata[34];
   assign req_cnt    = req_tdata[50:35];

   assign start_now     = (hint_ff < FIRST) ? FIRST : hint_ff;
   assign scan_nxt      = (cur_ff == LAST_C) ? FIRST : cur_ff + CW'(1);
   assign scan_nxt_wrap = wrap_ff || (cur_ff == LAST_C);
   assign run_end       = {1'b0, cl_ff} + 33'(cnt_ff);
   assign sect_off      = 48'(cur_ff - FIRST);

   // status toward the controller
   always_comb begin
      flags.mode       = mode_ff;
      flags.clear_done = (cur_ff == LAST_C);
      flags.contig     = contig_ff;
      flags.cl_lt2     = (cl_ff < 32'd2);
      flags.cl_gt_last = ({1'b0, cl_ff} > LAST_W);
      flags.run_past   = (run_end > LAST_W);
      flags.map_bit    = map_rd_ff;
      flags.nx_stop    = (tab_rd_ff == cca_pkg::END_MARK) || (tab_rd_ff < 32'd2) ||
                         ({1'b0, tab_rd_ff} > LAST_W);
      flags.scan_fail  = ((cur_ff == LAST_C) && wrap_ff) ||
                         (scan_nxt_wrap && (scan_nxt == start_ff));
      flags.idx_done   = (idx_ff == cnt_ff);
      flags.last_idx   = ({1'b0, idx_ff} + 17'd1) == {1'b0, cnt_ff};
      flags.cur_out    = flags.cl_gt_last || (cur_ff > LAST_C);
      flags.rsp_busy   = rsp_valid_ff && !rsp_tready;
   end

   // memory address and write data
   always_comb begin
      addr   = (cmd.op == cca_pkg::OP_A_LINK) ? AW'(cl_ff - 32'd2) : AW'(cur_ff - FIRST);
      map_we = 1'b0;
      map_wd = 1'b0;
      tab_we = 1'b0;
      tab_wd = 32'd0;
      unique case (cmd.op)
         cca_pkg::OP_CLR: begin
            map_we = 1'b1;
            tab_we = 1'b1;
         end
         cca_pkg::OP_A_MARK: begin
            map_we = 1'b1;
            map_wd = 1'b1;
            tab_we = 1'b1;
            tab_wd = cca_pkg::END_MARK;
         end
         cca_pkg::OP_A_LINK: begin
            tab_we = 1'b1;
            tab_wd = 32'(cur_ff);
         end
         cca_pkg::OP_FREE: begin
            map_we = 1'b1;
            tab_we = !contig_ff;
         end
         cca_pkg::OP_LINK: begin
            tab_we = 1'b1;
            tab_wd = flags.last_idx ? cca_pkg::END_MARK : 32'(cur_ff + CW'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem_ff[addr] <= map_wd;
      end
      if (tab_we) begin
         tab_mem_ff[addr] <= tab_wd;
      end
      map_rd_ff <= map_mem_ff[addr];
      tab_rd_ff <= tab_mem_ff[addr];
   end

   // next values of the job and result registers
   always_comb begin
      mode_in       = mode_ff;
      cl_in         = cl_ff;
      contig_in     = contig_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      wrap_in       = wrap_ff;
      hint_in       = hint_ff;
      free_in       = free_ff;
      hfs_in        = hfs_ff;
      spc_in        = spc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_sector_in = rsp_sector_ff;
      rsp_free_in   = rsp_free_ff;
      ok_found      = 1'b0;

      if (csr_we) begin
         if (csr_index == cca_pkg::CSR_HEAP_FIRST) begin
            hfs_in = csr_wdata;
         end else begin
            spc_in = csr_wdata[4:0];
         end
      end

      unique case (cmd.op)
         cca_pkg::OP_CLR: begin
            cur_in = cur_ff + CW'(1);
         end
         cca_pkg::OP_LOAD: begin
            mode_in   = req_mode;
            cl_in     = req_cl;
            contig_in = req_contig;
            cnt_in    = req_cnt;
            idx_in    = 16'd0;
            start_in  = start_now;
            wrap_in   = 1'b0;
            if (req_mode == cca_pkg::MODE_ALLOC) begin
               if (start_now > LAST_C) begin
                  cur_in  = FIRST;
                  wrap_in = 1'b1;
               end else begin
                  cur_in = start_now;
               end
            end else if (req_mode == cca_pkg::MODE_FIND && req_contig) begin
               cur_in = CW'(req_cl + 32'(req_cnt));
            end else begin
               cur_in = CW'(req_cl);
            end
         end
         cca_pkg::OP_A_NEXT: begin
            cur_in  = scan_nxt;
            wrap_in = scan_nxt_wrap;
         end
         cca_pkg::OP_A_MARK: begin
            if (free_ff != FW'(0)) begin
               free_in = free_ff - FW'(1);
            end
            hint_in = cur_ff + CW'(1);
         end
         cca_pkg::OP_FREE: begin
            if (map_rd_ff) begin
               free_in = free_ff + FW'(1);
            end
            if (cur_ff < hint_ff) begin
               hint_in = cur_ff;
            end
            if (contig_ff) begin
               cur_in = cur_ff + CW'(1);
               idx_in = idx_ff + 16'd1;
            end else begin
               cur_in = CW'(tab_rd_ff);
            end
         end
         cca_pkg::OP_FIND: begin
            cur_in = CW'(tab_rd_ff);
            idx_in = idx_ff + 16'd1;
         end
         cca_pkg::OP_LINK: begin
            cur_in = cur_ff + CW'(1);
            idx_in = idx_ff + 16'd1;
         end
         cca_pkg::OP_FIN: begin
            ok_found      = (cmd.status == cca_pkg::ST_OK) &&
                            (mode_ff == cca_pkg::MODE_ALLOC || mode_ff == cca_pkg::MODE_FIND);
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.status;
            rsp_found_in  = ok_found ? 13'(cur_ff) : 13'd0;
            rsp_sector_in = (ok_found && mode_ff == cca_pkg::MODE_FIND) ?
                            48'(hfs_ff) + (sect_off << spc_ff) : 48'd0;
            rsp_free_in   = 13'(free_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= FIRST;
         hint_ff      <= FIRST;
         free_ff      <= FW'(CLUSTERS);
         hfs_ff       <= 32'd0;
         spc_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         hint_ff      <= hint_in;
         free_ff      <= free_in;
         hfs_ff       <= hfs_in;
         spc_ff       <= spc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      cl_ff         <= cl_in;
      contig_ff     <= contig_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      start_ff      <= start_in;
      wrap_ff       <= wrap_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_free_ff, rsp_sector_ff, rsp_found_ff, rsp_status_ff};

endmodule

/* hdl/cca_ctrl.sv */
module cca_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  cca_pkg::flags_type flags,
   output cca_pkg::cmd_type   cmd
);

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_DISP   = 12'b0000_0000_0100,
      S_A_RD   = 12'b0000_0000_1000,
      S_A_CHK  = 12'b0000_0001_0000,
      S_A_LINK = 12'b0000_0010_0000,
      S_F_TEST = 12'b0000_0100_0000,
      S_F_ACT  = 12'b0000_1000_0000,
      S_N_RD   = 12'b0001_0000_0000,
      S_N_CHK  = 12'b0010_0000_0000,
      S_L_STEP = 12'b0100_0000_0000,
      S_FIN    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   cca_pkg::status_type st_ff, st_in;

   // sequence one operation
   always_comb begin
      state_in   = state_ff;
      st_in      = st_ff;
      req_tready = 1'b0;
      cmd.op     = cca_pkg::OP_NONE;
      cmd.status = st_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = cca_pkg::OP_CLR;
            if (flags.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = cca_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_FIN;
            st_in    = cca_pkg::ST_OK;
            unique case (flags.mode)
               cca_pkg::MODE_ALLOC: begin
                  if (flags.cl_gt_last) begin
                     st_in = cca_pkg::ST_BAD_CLUSTER;
                  end else begin
                     state_in = S_A_RD;
                  end
               end
               cca_pkg::MODE_FREE: begin
                  if (!flags.cl_lt2 && !flags.cl_gt_last) begin
                     state_in = S_F_TEST;
                  end
               end
               cca_pkg::MODE_FIND: begin
                  priority if (flags.cl_lt2) begin
                     st_in = cca_pkg::ST_PAST_END;
                  end else if (flags.cl_gt_last) begin
                     st_in = cca_pkg::ST_BAD_CLUSTER;
                  end else if (flags.contig) begin
                     if (flags.run_past) begin
                        st_in = cca_pkg::ST_PAST_END;
                     end
                  end else if (!flags.idx_done) begin
                     state_in = S_N_RD;
                  end
               end
               cca_pkg::MODE_LINK: begin
                  if (flags.contig && !flags.cl_lt2) begin
                     state_in = S_L_STEP;
                  end
               end
               default: begin
               end
            endcase
         end
         S_A_RD: begin
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            priority if (!flags.map_bit) begin
               cmd.op   = cca_pkg::OP_A_MARK;
               st_in    = cca_pkg::ST_OK;
               state_in = flags.cl_lt2 ? S_FIN : S_A_LINK;
            end else if (flags.scan_fail) begin
               st_in    = cca_pkg::ST_NO_FREE;
               state_in = S_FIN;
            end else begin
               cmd.op   = cca_pkg::OP_A_NEXT;
               state_in = S_A_RD;
            end
         end
         S_A_LINK: begin
            cmd.op   = cca_pkg::OP_A_LINK;
            state_in = S_FIN;
         end
         S_F_TEST: begin
            if (flags.contig && (flags.idx_done || flags.cur_out)) begin
               st_in    = cca_pkg::ST_OK;
               state_in = S_FIN;
            end else begin
               state_in = S_F_ACT;
            end
         end
         S_F_ACT: begin
            cmd.op = cca_pkg::OP_FREE;
            if (!flags.contig && flags.nx_stop) begin
               st_in    = cca_pkg::ST_OK;
               state_in = S_FIN;
            end else begin
               state_in = S_F_TEST;
            end
         end
         S_N_RD: begin
            state_in = S_N_CHK;
         end
         S_N_CHK: begin
            if (flags.nx_stop) begin
               st_in    = cca_pkg::ST_PAST_END;
               state_in = S_FIN;
            end else begin
               cmd.op = cca_pkg::OP_FIND;
               if (flags.last_idx) begin
                  st_in    = cca_pkg::ST_OK;
                  state_in = S_FIN;
               end else begin
                  state_in = S_N_RD;
               end
            end
         end
         S_L_STEP: begin
            priority if (flags.idx_done) begin
               st_in    = cca_pkg::ST_OK;
               state_in = S_FIN;
            end else if (flags.cur_out) begin
               st_in    = cca_pkg::ST_BAD_CLUSTER;
               state_in = S_FIN;
            end else begin
               cmd.op = cca_pkg::OP_LINK;
            end
         end
         S_FIN: begin
            if (!flags.rsp_busy) begin
               cmd.op   = cca_pkg::OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         st_ff    <= cca_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

endmodule

/* hdl/cluster_chain_allocator_core.sv */
// Flow: the request beat loads the job registers and a dispatch state checks it; then the
// allocate scan reads and tests map entries in turn, free visits each cluster freed, find
// follows each link and link writes each entry of the run; a final state registers the
// result once the previous one is taken. One operation at a time; the next beat is
// taken only after the result is registered and the block is back in idle.
// Reset (synchronous, active high): a clearing pass over all CLUSTERS entries zeroes map and
// table; no request beat is taken during it, csr writes are.
module cluster_chain_allocator_core #(
   parameter int unsigned CLUSTERS = cca_pkg::CLUSTERS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // mode[1:0], cluster[33:2], contiguous[34], count[50:35], zero pad
   input  logic [cca_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status[1:0], found_cluster[14:2], first_sector[62:15], free_total[75:63], zero pad
   output logic [cca_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [31:0]               csr_wdata
);

   cca_pkg::cmd_type   cmd;
   cca_pkg::flags_type flags;

   cca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   cca_dpath #(
      .CLUSTERS (CLUSTERS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .flags      (flags),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // free count never exceeds the heap
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[75:63] <= 13'(CLUSTERS)))
      else $error("free_total above cluster count");

   // no free cluster only when the count says so
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == cca_pkg::ST_NO_FREE) |-> (rsp_tdata[75:63] == 13'd0))
      else $error("no-free status with free clusters left");

   // a reported cluster is a data cluster
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[14:2] != 13'd0) |->
         (rsp_tdata[14:2] >= 13'd2 && rsp_tdata[14:2] <= 13'(CLUSTERS + 1)))
      else $error("found cluster out of range");

   // load a job only on an accepted request beat
   a_load_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cca_pkg::OP_LOAD) |-> (req_tvalid && req_tready))
      else $error("load without request beat");
`endif

endmodule

/* tb/cluster_chain_allocator_core_tb.sv */
`timescale 1ns / 100ps

module cluster_chain_allocator_core_tb;

   localparam int unsigned N_CL     = cca_pkg::CLUSTERS_DEF;
   localparam longint unsigned LAST = N_CL + 1;
   localparam int unsigned STALL_LIMIT = 100000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [cca_pkg::REQ_W-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [cca_pkg::RSP_W-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic                      csr_index = cca_pkg::CSR_HEAP_FIRST;
   logic [31:0]               csr_wdata = '0;

   cluster_chain_allocator_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   typedef struct {
      cca_pkg::status_type st;
      logic [12:0]         found;
      logic [47:0]         sector;
      logic [12:0]         free_total;
   } alloc_result_type;

   // Mirror of the map, chain table, hint and free count; queues expected results.
   class alloc_scoreboard;
      bit                 map_used[N_CL];
      logic [31:0]        link_tbl[N_CL];
      longint unsigned    hint;
      longint unsigned    free_cnt;
      logic [31:0]        heap_first;
      logic [4:0]         spc_log2;
      alloc_result_type   pending_q[$];
      int                 mismatches;
      int                 results_seen;

      function void clear();
         foreach (map_used[i]) begin
            map_used[i] = 1'b0;
            link_tbl[i] = '0;
         end
         hint = 2;
         free_cnt = N_CL;
         heap_first = '0;
         spc_log2 = '0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void write_cfg(logic idx, logic [31:0] v);
         if (idx == cca_pkg::CSR_HEAP_FIRST) heap_first = v;
         else spc_log2 = v[4:0];
      endfunction

      function bit valid_cl(longint unsigned c);
         return c >= 2 && c <= LAST;
      endfunction

      function void release_cluster(longint unsigned c);
         if (map_used[c-2]) begin
            map_used[c-2] = 1'b0;
            free_cnt++;
         end
         if (c < hint) hint = c;
      endfunction

      // Predict one operation; return the cluster it allocates or finds.
      function logic [12:0] note_request(cca_pkg::mode_type m, logic [31:0] cl_in,
                                         bit contig, logic [15:0] cnt);
         longint unsigned  cl, c, start, stop, nx, i;
         bit               hit;
         alloc_result_type r;
         cl = cl_in;
         r.st = cca_pkg::ST_OK;
         r.found = '0;
         r.sector = '0;
         hit = 1'b0;
         c = 0;
         case (m)
            cca_pkg::MODE_ALLOC: begin
               start = (hint < 2) ? 2 : hint;
               if (cl >= 2 && cl > LAST) begin
                  r.st = cca_pkg::ST_BAD_CLUSTER;
               end else begin
                  for (i = start; i <= LAST && !hit; i++)
                     if (!map_used[i-2]) begin hit = 1'b1; c = i; end
                  stop = (start < LAST + 1) ? start : LAST + 1;
                  for (i = 2; i < stop && !hit; i++)
                     if (!map_used[i-2]) begin hit = 1'b1; c = i; end
                  if (hit) begin
                     map_used[c-2] = 1'b1;
                     if (free_cnt > 0) free_cnt--;
                     link_tbl[c-2] = cca_pkg::END_MARK;
                     if (cl >= 2) link_tbl[cl-2] = c[31:0];
                     hint = c + 1;
                     r.found = c[12:0];
                  end else begin
                     r.st = cca_pkg::ST_NO_FREE;
                  end
               end
            end
            cca_pkg::MODE_FREE: begin
               if (cl >= 2) begin
                  if (contig) begin
                     for (i = 0; i < cnt && cl + i <= LAST; i++)
                        release_cluster(cl + i);
                  end else begin
                     c = cl;
                     while (valid_cl(c)) begin
                        nx = link_tbl[c-2];
                        link_tbl[c-2] = '0;
                        release_cluster(c);
                        if (nx == cca_pkg::END_MARK || !valid_cl(nx)) break;
                        c = nx;
                     end
                  end
               end
            end
            cca_pkg::MODE_FIND: begin
               if (cl < 2) r.st = cca_pkg::ST_PAST_END;
               else if (cl > LAST) r.st = cca_pkg::ST_BAD_CLUSTER;
               else begin
                  c = cl;
                  if (contig) begin
                     c = cl + cnt;
                     if (c > LAST) r.st = cca_pkg::ST_PAST_END;
                  end else begin
                     for (i = 0; i < cnt; i++) begin
                        nx = link_tbl[c-2];
                        if (nx == cca_pkg::END_MARK || !valid_cl(nx)) begin
                           r.st = cca_pkg::ST_PAST_END;
                           break;
                        end
                        c = nx;
                     end
                  end
                  if (r.st == cca_pkg::ST_OK) begin
                     r.found = c[12:0];
                     r.sector = 48'(heap_first) + (48'(c - 2) << spc_log2);
                  end
               end
            end
            default: begin
               if (contig && cl >= 2) begin
                  for (i = 0; i < cnt; i++) begin
                     c = cl + i;
                     if (c > LAST) begin
                        r.st = cca_pkg::ST_BAD_CLUSTER;
                        break;
                     end
                     link_tbl[c-2] = (i + 1 < cnt) ? 32'(c + 1) : cca_pkg::END_MARK;
                  end
               end
            end
         endcase
         r.free_total = free_cnt[12:0];
         pending_q.push_back(r);
         return r.found;
      endfunction

      function void flag(string what, logic [47:0] exp_v, logic [47:0] act_v);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH %s: expected %0h actual %0h", what, exp_v, act_v);
      endfunction

      function void check_result(logic [cca_pkg::RSP_W-1:0] d);
         alloc_result_type e;
         results_seen++;
         if (pending_q.size() == 0) begin
            flag("unexpected beat", '0, d[47:0]);
            return;
         end
         e = pending_q.pop_front();
         if (d[1:0] !== e.st) flag("status", e.st, d[1:0]);
         if (d[14:2] !== e.found) flag("found_cluster", e.found, d[14:2]);
         if (d[62:15] !== e.sector) flag("first_sector", e.sector, d[62:15]);
         if (d[75:63] !== e.free_total) flag("free_total", e.free_total, d[75:63]);
      endfunction
   endclass

   alloc_scoreboard sb;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  rsp_hold = 1'b0;
   int  items_sent = 0;
   int  idle_cycles = 0;
   logic [31:0] chain_head = 2;
   logic [31:0] chain_tail = 0;

   // Drain results, drive ready, and watch for a hung block.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("cluster_chain_allocator_core test failed");
            $finish;
         end
         rsp_tready <= rsp_hold ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_op(cca_pkg::mode_type m, logic [31:0] cl, bit contig,
                          logic [15:0] cnt);
      logic [12:0] f;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, cnt, contig, cl, m};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      f = sb.note_request(m, cl, contig, cnt);
      items_sent++;
      if (m == cca_pkg::MODE_ALLOC && f != 0) begin
         if (cl < 2) chain_head = {19'b0, f};
         chain_tail = {19'b0, f};
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_cfg(idx, v);
   endtask

   function automatic logic [31:0] pick_cluster();
      if ($urandom_range(9) == 0) return $urandom;
      return $urandom_range(70, 0);
   endfunction

   // Mostly chain building and walking, with some noise mixed in.
   task automatic random_op();
      int k;
      k = $urandom_range(99);
      if (k < 35) begin
         if ($urandom_range(4) == 0)
            send_op(cca_pkg::MODE_ALLOC, 0, 1'($urandom_range(1)), 16'($urandom));
         else if (k == 0)
            send_op(cca_pkg::MODE_ALLOC, $urandom_range(32'hFFFF_FFFF, 4098), 0, 0);
         else
            send_op(cca_pkg::MODE_ALLOC, chain_tail, 1'($urandom_range(1)), 16'($urandom));
      end else if (k < 55) begin
         send_op(cca_pkg::MODE_FIND, chain_head, $urandom_range(4) == 0,
                 16'($urandom_range(8)));
      end else if (k < 68) begin
         if ($urandom_range(4) == 0)
            send_op(cca_pkg::MODE_FREE, chain_head, 1'b1, 16'($urandom_range(12)));
         else
            send_op(cca_pkg::MODE_FREE, chain_head, 1'b0, 16'($urandom));
         chain_tail = 0;
      end else if (k < 80) begin
         chain_head = $urandom_range(60, 2);
         send_op(cca_pkg::MODE_LINK, chain_head, 1'b1, 16'($urandom_range(10)));
      end else if (k < 92) begin
         send_op(cca_pkg::mode_type'($urandom_range(3)), pick_cluster(),
                 1'($urandom_range(1)),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12)));
      end else begin
         send_op(cca_pkg::MODE_FIND, pick_cluster(), 1'($urandom_range(1)),
                 16'($urandom_range(6)));
      end
   endtask

   initial begin
      int ph;
      sb = new();
      sb.clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: limits of each field, each operation and its corner cases.
      send_op(cca_pkg::MODE_ALLOC, 0, 0, 0);
      send_op(cca_pkg::MODE_ALLOC, 2, 0, 0);
      send_op(cca_pkg::MODE_ALLOC, 4097, 1, 16'hFFFF);
      send_op(cca_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 0, 0);
      send_op(cca_pkg::MODE_FIND, 2, 0, 0);
      send_op(cca_pkg::MODE_FIND, 2, 0, 1);
      send_op(cca_pkg::MODE_FIND, 2, 0, 5);
      send_op(cca_pkg::MODE_FIND, 0, 0, 0);
      send_op(cca_pkg::MODE_FIND, 4098, 0, 0);
      send_op(cca_pkg::MODE_FIND, 4000, 1, 16'hFFFF);
      send_op(cca_pkg::MODE_FIND, 2, 1, 4095);
      send_op(cca_pkg::MODE_FREE, 1, 0, 0);
      send_op(cca_pkg::MODE_LINK, 40, 0, 4);
      send_op(cca_pkg::MODE_LINK, 0, 1, 4);
      send_op(cca_pkg::MODE_LINK, 4090, 1, 20);
      send_op(cca_pkg::MODE_FIND, 4090, 0, 7);
      send_op(cca_pkg::MODE_FIND, 4090, 0, 8);
      send_op(cca_pkg::MODE_LINK, 30, 1, 2);
      send_op(cca_pkg::MODE_FREE, 31, 0, 0);
      send_op(cca_pkg::MODE_FREE, 30, 0, 0);
      send_op(cca_pkg::MODE_LINK, 50, 1, 0);
      send_op(cca_pkg::MODE_FREE, 2, 0, 0);
      send_op(cca_pkg::MODE_FREE, 4090, 1, 16'hFFFF);
      drain();

      // Extreme register values, then free and reallocate around long runs.
      write_csr(cca_pkg::CSR_HEAP_FIRST, 32'hFFFF_FFFF);
      write_csr(cca_pkg::CSR_SPC_LOG2, 32'd16);
      send_op(cca_pkg::MODE_FIND, 4097, 1, 0);
      send_op(cca_pkg::MODE_FIND, 2, 1, 100);
      send_op(cca_pkg::MODE_ALLOC, 0, 0, 0);
      send_op(cca_pkg::MODE_FREE, 4000, 1, 16'hFFFF);
      send_op(cca_pkg::MODE_ALLOC, 0, 0, 0);
      send_op(cca_pkg::MODE_FREE, 2, 1, 16'hFFFF);
      drain();

      // Random phases, each with its own idle pattern and register setting.
      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 76; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 76; end
            default: begin send_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         write_csr(cca_pkg::CSR_HEAP_FIRST, (ph == 0) ? 32'd0 : $urandom);
         write_csr(cca_pkg::CSR_SPC_LOG2, (ph == 0) ? 32'd0 : $urandom_range(16));
         if (ph == 3) begin
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (600) @(posedge clock);
                  rsp_hold = 1'b0;
               end
               repeat (28) random_op();
            join
         end else begin
            repeat (28) random_op();
         end
         drain();
      end

      repeat (200) @(posedge clock);
      $display("ran %0d operations, %0d results checked: directed corners, long runs,",
               items_sent, sb.results_seen);
      $display("random chain build/walk/free/link under four idle patterns and a long stall");
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("cluster_chain_allocator_core test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
         $display("cluster_chain_allocator_core test failed");
      end
      $finish;
   end

endmodule
